FILE: rtl/obb_pkg.sv
// Shared constants for the oriented-box separating-axis overlap test.
`timescale 1ns / 1ps
package obb_pkg;

    localparam int COMP_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int FIELD_BITS    = 48;
    localparam int NUM_BOX_AXES  = 6;
    localparam int NUM_AXES      = 15;
    localparam int NUM_DIMS      = 3;
    localparam int QUEUE_DEPTH   = 2;

endpackage

FILE: rtl/obb_front.sv
// Front stage: unpacks a box pair, forms the center difference and the nine cross-product axes.
`timescale 1ns / 1ps
module obb_front #(
    parameter int COMP_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_center,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_axis_x,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_axis_y,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_axis_z,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_lengths,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_center,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_axis_x,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_axis_y,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_axis_z,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_lengths,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [(obb_pkg::NUM_DIMS*(COMP_BITS+1)
                   + obb_pkg::NUM_AXES*obb_pkg::NUM_DIMS*(2*COMP_BITS+1)
                   + obb_pkg::NUM_BOX_AXES*obb_pkg::NUM_DIMS*COMP_BITS
                   + obb_pkg::NUM_BOX_AXES*COMP_BITS)-1:0] out_item
);
    import obb_pkg::*;

    localparam int C      = COMP_BITS;
    localparam int LW     = 2 * C + 1;
    localparam int PW     = (3 * C > FIELD_BITS) ? 3 * C : FIELD_BITS;
    localparam int OFF_L  = NUM_DIMS * (C + 1);
    localparam int OFF_AX = OFF_L + NUM_AXES * NUM_DIMS * LW;
    localparam int OFF_LN = OFF_AX + NUM_BOX_AXES * NUM_DIMS * C;
    localparam int ITEM_W = OFF_LN + NUM_BOX_AXES * C;

    logic [PW-1:0]          words [10];
    logic signed [C-1:0]    ca [NUM_DIMS];
    logic signed [C-1:0]    cb [NUM_DIMS];
    logic signed [C-1:0]    axv [NUM_BOX_AXES][NUM_DIMS];
    logic [C-1:0]           lenv [NUM_BOX_AXES];
    logic signed [C:0]      dv [NUM_DIMS];
    logic signed [2*C-1:0]  m0 [NUM_AXES][NUM_DIMS];
    logic signed [2*C-1:0]  m1 [NUM_AXES][NUM_DIMS];
    logic signed [LW-1:0]   lv [NUM_AXES][NUM_DIMS];
    logic [ITEM_W-1:0]      item_next;
    logic [ITEM_W-1:0]      item_reg;
    logic                   valid_reg;
    logic                   valid_next;

    always_comb
    begin
        words[0] = PW'(a_center);
        words[1] = PW'(a_axis_x);
        words[2] = PW'(a_axis_y);
        words[3] = PW'(a_axis_z);
        words[4] = PW'(a_lengths);
        words[5] = PW'(b_center);
        words[6] = PW'(b_axis_x);
        words[7] = PW'(b_axis_y);
        words[8] = PW'(b_axis_z);
        words[9] = PW'(b_lengths);
        for (int c = 0; c < NUM_DIMS; c++)
        begin
            ca[c] = $signed(words[0][c*C +: C]);
            cb[c] = $signed(words[5][c*C +: C]);
            dv[c] = (C+1)'(ca[c]) - (C+1)'(cb[c]);
            for (int i = 0; i < 3; i++)
            begin
                axv[i][c]     = $signed(words[1+i][c*C +: C]);
                axv[3+i][c]   = $signed(words[6+i][c*C +: C]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            lenv[i]   = words[4][i*C +: C];
            lenv[3+i] = words[9][i*C +: C];
        end
        for (int k = 0; k < NUM_BOX_AXES; k++)
        begin
            for (int c = 0; c < NUM_DIMS; c++)
            begin
                m0[k][c] = '0;
                m1[k][c] = '0;
                lv[k][c] = LW'(axv[k][c]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                m0[6+3*i+j][0] = axv[i][1] * axv[3+j][2];
                m1[6+3*i+j][0] = axv[i][2] * axv[3+j][1];
                m0[6+3*i+j][1] = axv[i][2] * axv[3+j][0];
                m1[6+3*i+j][1] = axv[i][0] * axv[3+j][2];
                m0[6+3*i+j][2] = axv[i][0] * axv[3+j][1];
                m1[6+3*i+j][2] = axv[i][1] * axv[3+j][0];
                for (int c = 0; c < NUM_DIMS; c++)
                begin
                    lv[6+3*i+j][c] = LW'(m0[6+3*i+j][c]) - LW'(m1[6+3*i+j][c]);
                end
            end
        end
        item_next = '0;
        for (int c = 0; c < NUM_DIMS; c++)
        begin
            item_next[c*(C+1) +: C+1] = dv[c];
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int c = 0; c < NUM_DIMS; c++)
            begin
                item_next[OFF_L + (a*NUM_DIMS+c)*LW +: LW] = lv[a][c];
            end
        end
        for (int k = 0; k < NUM_BOX_AXES; k++)
        begin
            for (int c = 0; c < NUM_DIMS; c++)
            begin
                item_next[OFF_AX + (k*NUM_DIMS+c)*C +: C] = axv[k][c];
            end
            item_next[OFF_LN + k*C +: C] = lenv[k];
        end
    end

    assign in_stall   = valid_reg && out_stall;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/obb_queue.sv
// Short queue that decouples the front stage from the evaluation pipeline.
`timescale 1ns / 1ps
module obb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] out_item
);
    import obb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_stall  = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/obb_back.sv
// Evaluation pipeline: projects both boxes on all fifteen axes and reports overlap.
`timescale 1ns / 1ps
module obb_back #(
    parameter int COMP_BITS = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [(obb_pkg::NUM_DIMS*(COMP_BITS+1)
                   + obb_pkg::NUM_AXES*obb_pkg::NUM_DIMS*(2*COMP_BITS+1)
                   + obb_pkg::NUM_BOX_AXES*obb_pkg::NUM_DIMS*COMP_BITS
                   + obb_pkg::NUM_BOX_AXES*COMP_BITS)-1:0] in_item,
    output logic out_valid,
    input  logic out_stall,
    output logic overlap
);
    import obb_pkg::*;

    localparam int C      = COMP_BITS;
    localparam int LW     = 2 * C + 1;
    localparam int DPW    = 3 * C + 2;
    localparam int APW    = 3 * C + 1;
    localparam int DSW    = 3 * C + 4;
    localparam int ASW    = 3 * C + 3;
    localparam int RAW    = 4 * C + 3;
    localparam int RPW    = 4 * C + 4;
    localparam int W      = 4 * C + FRAC_BITS + 6;
    localparam int OFF_L  = NUM_DIMS * (C + 1);
    localparam int OFF_AX = OFF_L + NUM_AXES * NUM_DIMS * LW;
    localparam int OFF_LN = OFF_AX + NUM_BOX_AXES * NUM_DIMS * C;
    localparam int STAGES = 6;

    logic signed [C:0]     dv [NUM_DIMS];
    logic signed [LW-1:0]  lv [NUM_AXES][NUM_DIMS];
    logic signed [C-1:0]   axv [NUM_BOX_AXES][NUM_DIMS];
    logic [C-1:0]          lenv [NUM_BOX_AXES];

    logic [STAGES-1:0]     v_reg;
    logic                  en;

    logic signed [DPW-1:0] pd_reg [NUM_AXES][NUM_DIMS];
    logic signed [APW-1:0] pa_reg [NUM_AXES][NUM_BOX_AXES][NUM_DIMS];
    logic [C-1:0]          len1_reg [NUM_BOX_AXES];
    logic [C-1:0]          len2_reg [NUM_BOX_AXES];
    logic signed [DSW-1:0] sd [NUM_AXES];
    logic signed [ASW-1:0] sa [NUM_AXES][NUM_BOX_AXES];
    logic [DSW-1:0]        absd_reg [NUM_AXES];
    logic [ASW-1:0]        absa_reg [NUM_AXES][NUM_BOX_AXES];
    logic [W-1:0]          lhs3_reg [NUM_AXES];
    logic [RAW-1:0]        ra_reg [NUM_AXES][NUM_BOX_AXES];
    logic [W-1:0]          lhs4_reg [NUM_AXES];
    logic [RPW-1:0]        rp_reg [NUM_AXES][3];
    logic [W-1:0]          rhs [NUM_AXES];
    logic [NUM_AXES-1:0]   sep_reg;
    logic                  overlap_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_DIMS; c++)
        begin
            dv[c] = $signed(in_item[c*(C+1) +: C+1]);
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int c = 0; c < NUM_DIMS; c++)
            begin
                lv[a][c] = $signed(in_item[OFF_L + (a*NUM_DIMS+c)*LW +: LW]);
            end
        end
        for (int k = 0; k < NUM_BOX_AXES; k++)
        begin
            for (int c = 0; c < NUM_DIMS; c++)
            begin
                axv[k][c] = $signed(in_item[OFF_AX + (k*NUM_DIMS+c)*C +: C]);
            end
            lenv[k] = in_item[OFF_LN + k*C +: C];
        end
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sd[a] = DSW'(pd_reg[a][0]) + DSW'(pd_reg[a][1]) + DSW'(pd_reg[a][2]);
            for (int k = 0; k < NUM_BOX_AXES; k++)
            begin
                sa[a][k] = ASW'(pa_reg[a][k][0]) + ASW'(pa_reg[a][k][1])
                         + ASW'(pa_reg[a][k][2]);
            end
            rhs[a] = W'(rp_reg[a][0]) + W'(rp_reg[a][1]) + W'(rp_reg[a][2]);
        end
    end

    assign en       = !(v_reg[STAGES-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                for (int c = 0; c < NUM_DIMS; c++)
                begin
                    pd_reg[a][c] <= dv[c] * lv[a][c];
                    for (int k = 0; k < NUM_BOX_AXES; k++)
                    begin
                        pa_reg[a][k][c] <= lv[a][c] * axv[k][c];
                    end
                end
                absd_reg[a] <= DSW'(sd[a][DSW-1] ? -sd[a] : sd[a]);
                for (int k = 0; k < NUM_BOX_AXES; k++)
                begin
                    absa_reg[a][k] <= ASW'(sa[a][k][ASW-1] ? -sa[a][k] : sa[a][k]);
                    ra_reg[a][k]   <= RAW'(absa_reg[a][k]) * RAW'(len2_reg[k]);
                end
                lhs3_reg[a] <= W'(absd_reg[a]) << (FRAC_BITS + 1);
                lhs4_reg[a] <= lhs3_reg[a];
                for (int m = 0; m < 3; m++)
                begin
                    rp_reg[a][m] <= RPW'(ra_reg[a][2*m]) + RPW'(ra_reg[a][2*m+1]);
                end
                sep_reg[a] <= (lhs4_reg[a] > rhs[a]);
            end
            for (int k = 0; k < NUM_BOX_AXES; k++)
            begin
                len1_reg[k] <= lenv[k];
                len2_reg[k] <= len1_reg[k];
            end
            overlap_reg <= ~|sep_reg;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign overlap   = overlap_reg;

endmodule

FILE: rtl/obb_overlap_separating_axis.sv
// Top level of the oriented-box overlap test over fifteen separating axes.
`timescale 1ns / 1ps
// Takes one box pair per cycle while in_stall is low and returns one overlap bit per pair, in
// order. A pair passes through the front stage register, the two-entry queue and the
// evaluation pipeline; all fifteen axes are tested in parallel, which lets a new pair enter
// every cycle when nothing stalls. Touching boxes count as overlapping, and a zero axis never
// separates.
module obb_overlap_separating_axis #(
    parameter int COMP_BITS = obb_pkg::COMP_BITS_DEF,
    parameter int FRAC_BITS = obb_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_center,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_axis_x,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_axis_y,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_axis_z,
    input  logic [obb_pkg::FIELD_BITS-1:0] a_lengths,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_center,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_axis_x,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_axis_y,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_axis_z,
    input  logic [obb_pkg::FIELD_BITS-1:0] b_lengths,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          overlap
);
    import obb_pkg::*;

    localparam int C      = COMP_BITS;
    localparam int ITEM_W = NUM_DIMS * (C + 1) + NUM_AXES * NUM_DIMS * (2 * C + 1)
                          + NUM_BOX_AXES * NUM_DIMS * C + NUM_BOX_AXES * C;

    logic              f_valid;
    logic              f_stall;
    logic [ITEM_W-1:0] f_item;
    logic              q_valid;
    logic              q_stall;
    logic [ITEM_W-1:0] q_item;

    obb_front #(
        .COMP_BITS (COMP_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .a_center  (a_center),
        .a_axis_x  (a_axis_x),
        .a_axis_y  (a_axis_y),
        .a_axis_z  (a_axis_z),
        .a_lengths (a_lengths),
        .b_center  (b_center),
        .b_axis_x  (b_axis_x),
        .b_axis_y  (b_axis_y),
        .b_axis_z  (b_axis_z),
        .b_lengths (b_lengths),
        .out_valid (f_valid),
        .out_stall (f_stall),
        .out_item  (f_item)
    );

    obb_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_stall (q_stall),
        .out_item  (q_item)
    );

    obb_back #(
        .COMP_BITS (COMP_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_stall  (q_stall),
        .in_item   (q_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .overlap   (overlap)
    );

    a_front_stall_needs_full_queue : assert property (
        @(posedge clk) disable iff (!rst_n) in_stall |-> f_stall
    ) else $error("Front stage stalled while the queue had room.");

    a_back_stall_needs_held_output : assert property (
        @(posedge clk) disable iff (!rst_n) q_stall |-> (out_valid && out_stall)
    ) else $error("Pipeline stalled without a held result transfer.");

    a_idle_pipeline_no_stall : assert property (
        @(posedge clk) disable iff (!rst_n) !out_valid |-> !q_stall
    ) else $error("Pipeline stalled with an empty output stage.");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the oriented-box separating-axis overlap test.
`timescale 1ns / 1ps
module testbench;

    localparam int CB = obb_pkg::COMP_BITS_DEF;
    localparam int FB = obb_pkg::FRAC_BITS_DEF;
    localparam int FW = obb_pkg::FIELD_BITS;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [63:0] s64_t;
    typedef logic signed [127:0] s128_t;

    typedef struct packed {
        logic [FW-1:0] a_center;
        logic [FW-1:0] a_axis_x;
        logic [FW-1:0] a_axis_y;
        logic [FW-1:0] a_axis_z;
        logic [FW-1:0] a_lengths;
        logic [FW-1:0] b_center;
        logic [FW-1:0] b_axis_x;
        logic [FW-1:0] b_axis_y;
        logic [FW-1:0] b_axis_z;
        logic [FW-1:0] b_lengths;
    } box_pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic overlap;
    box_pair_t pair = '0;

    logic expected_overlap[$];
    int errors = 0;
    int cycles = 0;
    bit idle_enable = 1'b1;

    obb_overlap_separating_axis dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .a_center(pair.a_center),
        .a_axis_x(pair.a_axis_x),
        .a_axis_y(pair.a_axis_y),
        .a_axis_z(pair.a_axis_z),
        .a_lengths(pair.a_lengths),
        .b_center(pair.b_center),
        .b_axis_x(pair.b_axis_x),
        .b_axis_y(pair.b_axis_y),
        .b_axis_z(pair.b_axis_z),
        .b_lengths(pair.b_lengths),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .overlap(overlap)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic s64_t comp_s(logic [FW-1:0] w, int i);
        logic [CB-1:0] c;
        c = w[i*CB +: CB];
        return s64_t'($signed(c));
    endfunction

    function automatic s128_t mag_dot(s64_t u[3], s64_t v[3]);
        s128_t s;
        s = s128_t'(u[0]) * v[0] + s128_t'(u[1]) * v[1] + s128_t'(u[2]) * v[2];
        return (s < 0) ? -s : s;
    endfunction

    function automatic logic boxes_overlap(box_pair_t p);
        s64_t ax[6][3];
        s64_t len[6];
        s64_t d[3];
        s64_t l[3];
        s128_t lhs;
        s128_t rhs;
        logic [FW-1:0] w[6];
        w = '{p.a_axis_x, p.a_axis_y, p.a_axis_z, p.b_axis_x, p.b_axis_y, p.b_axis_z};
        for (int i = 0; i < 3; i++)
        begin
            d[i] = comp_s(p.a_center, i) - comp_s(p.b_center, i);
            len[i] = s64_t'(p.a_lengths[i*CB +: CB]);
            len[3+i] = s64_t'(p.b_lengths[i*CB +: CB]);
        end
        for (int k = 0; k < 6; k++)
            for (int i = 0; i < 3; i++)
                ax[k][i] = comp_s(w[k], i);
        for (int n = 0; n < 15; n++)
        begin
            if (n < 6)
                l = ax[n];
            else
            begin
                int i;
                int j;
                i = (n - 6) / 3;
                j = 3 + (n - 6) % 3;
                l[0] = ax[i][1] * ax[j][2] - ax[i][2] * ax[j][1];
                l[1] = ax[i][2] * ax[j][0] - ax[i][0] * ax[j][2];
                l[2] = ax[i][0] * ax[j][1] - ax[i][1] * ax[j][0];
            end
            lhs = mag_dot(d, l) * (s128_t'(1) << (FB + 1));
            rhs = 0;
            for (int k = 0; k < 6; k++)
                rhs += mag_dot(l, ax[k]) * len[k];
            if (lhs > rhs)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic send_pair(box_pair_t p);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_overlap.push_back(boxes_overlap(p));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_overlap.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual overlap %0b", $time, overlap);
                errors++;
            end
            else
            begin
                logic e;
                e = expected_overlap.pop_front();
                if (e !== overlap)
                begin
                    $display("%0t: overlap expected %0b actual %0b", $time, e, overlap);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int burst;
        @(posedge clk);
        while (1)
        begin
            if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    function automatic logic [FW-1:0] pack3(int x, int y, int z);
        logic [FW-1:0] w;
        w = '0;
        w[0 +: CB] = x[CB-1:0];
        w[CB +: CB] = y[CB-1:0];
        w[2*CB +: CB] = z[CB-1:0];
        return w;
    endfunction

    function automatic logic [FW-1:0] rand_field();
        return FW'({$urandom(), $urandom()});
    endfunction

    function automatic logic [FW-1:0] small_vec(int r);
        return pack3($urandom_range(0, 2*r) - r, $urandom_range(0, 2*r) - r,
                     $urandom_range(0, 2*r) - r);
    endfunction

    function automatic box_pair_t unit_boxes(int dx, int dy, int dz, int len);
        box_pair_t p;
        p.a_center = pack3(dx, dy, dz);
        p.b_center = '0;
        p.a_axis_x = pack3(256, 0, 0);
        p.a_axis_y = pack3(0, 256, 0);
        p.a_axis_z = pack3(0, 0, 256);
        p.b_axis_x = p.a_axis_x;
        p.b_axis_y = p.a_axis_y;
        p.b_axis_z = p.a_axis_z;
        p.a_lengths = pack3(len, len, len);
        p.b_lengths = pack3(len, len, len);
        return p;
    endfunction

    task automatic test_directed();
        box_pair_t p;
        send_pair(unit_boxes(0, 0, 0, 256));
        send_pair(unit_boxes(256, 0, 0, 256));
        send_pair(unit_boxes(257, 0, 0, 256));
        send_pair(unit_boxes(0, -257, 0, 256));
        send_pair(unit_boxes(0, 0, 255, 256));
        p = unit_boxes(100, 0, 0, 0);
        send_pair(p);
        p = unit_boxes(0, 0, 0, 256);
        p.a_axis_x = '0;
        p.b_axis_y = '0;
        send_pair(p);
        p = '0;
        send_pair(p);
        p = '1;
        send_pair(p);
        p = unit_boxes(-32768, 32767, -32768, 65535);
        send_pair(p);
        p = unit_boxes(32767, 32767, 32767, 0);
        p.a_axis_x = pack3(-32768, -32768, -32768);
        p.b_axis_z = pack3(32767, 32767, 32767);
        send_pair(p);
        p = unit_boxes(300, 300, 0, 256);
        p.a_axis_x = pack3(181, 181, 0);
        p.a_axis_y = pack3(-181, 181, 0);
        send_pair(p);
        p = unit_boxes(0, 0, 0, 256);
        p.a_center = pack3(10, 0, 0);
        p.b_lengths = pack3(0, 0, 0);
        send_pair(p);
        for (int i = 0; i < 8; i++)
        begin
            p = unit_boxes(0, 0, 0, 256);
            p.a_center = rand_field();
            p.a_axis_x = rand_field();
            p.b_axis_y = rand_field();
            p.a_lengths = rand_field();
            send_pair(p);
        end
    endtask

    task automatic test_random(int count);
        box_pair_t p;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                p.a_center = rand_field();
                p.a_axis_x = rand_field();
                p.a_axis_y = rand_field();
                p.a_axis_z = rand_field();
                p.a_lengths = rand_field();
                p.b_center = rand_field();
                p.b_axis_x = rand_field();
                p.b_axis_y = rand_field();
                p.b_axis_z = rand_field();
                p.b_lengths = rand_field();
            end
            else
            begin
                p.a_center = small_vec(1200);
                p.b_center = small_vec(1200);
                p.a_axis_x = small_vec(400);
                p.a_axis_y = small_vec(400);
                p.a_axis_z = small_vec(400);
                p.b_axis_x = small_vec(400);
                p.b_axis_y = small_vec(400);
                p.b_axis_z = small_vec(400);
                p.a_lengths = pack3($urandom_range(0, 1500), $urandom_range(0, 1500),
                                    $urandom_range(0, 1500));
                p.b_lengths = pack3($urandom_range(0, 1500), $urandom_range(0, 1500),
                                    $urandom_range(0, 1500));
            end
            send_pair(p);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(380);
        idle_enable = 1'b0;
        test_random(100);
        in_valid <= 1'b0;
        while (expected_overlap.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
